// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define TBP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TBP_ASSERT_SAME(label, clk, rst, ante, cons)
`define TBP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/tbp_pkg.sv -----
`default_nettype none

package tbp_pkg;

   localparam int GHIST_BITS_DEF    = 9;
   localparam int LHIST_BITS_DEF    = 10;
   localparam int PC_INDEX_BITS_DEF = 10;

   localparam int PC_BITS = 32;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_MAX         = 2'd3;
   localparam ctr_type CTR_MIN         = 2'd0;
   localparam ctr_type CTR_WEAK_NT     = 2'd1;
   localparam ctr_type CTR_WEAK_GLOBAL = 2'd2;

   typedef enum logic [0:0] {
      OP_PREDICT = 1'b0,
      OP_TRAIN   = 1'b1
   } opcode_type;

   localparam logic MODE_STATIC     = 1'b0;
   localparam logic MODE_TOURNAMENT = 1'b1;

   // Saturating 2-bit counter step.
   function automatic ctr_type bump(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = 2'(c + 2'd1);
      end else begin
         if (c != CTR_MIN) r = 2'(c - 2'd1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tbp_channels.sv -----
`default_nettype none

interface tbp_req_if import tbp_pkg::*; ();
   logic                valid;
   logic                ready;
   opcode_type          opcode;
   logic [PC_BITS-1:0]  branch_pc;
   logic                actual_taken;

   modport source (output valid, output opcode, output branch_pc, output actual_taken,
                   input ready);
   modport sink   (input valid, input opcode, input branch_pc, input actual_taken,
                   output ready);
endinterface

interface tbp_rsp_if ();
   logic valid;
   logic ready;
   logic predict_taken;

   modport source (output valid, output predict_taken, input ready);
   modport sink   (input valid, input predict_taken, output ready);
endinterface

`default_nettype wire

// ----- rtl/tbp_ram.sv -----
`default_nettype none

module tbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- rtl/tournament_branch_predictor.sv -----
// Channel   Dir  Payload                              Transaction
// req_ch    in   opcode, branch_pc, actual_taken      valid & ready
// rsp_ch    out  predict_taken (predict only)         valid & ready
// csr       in   csr_wdata = predictor_mode           csr_we
//
// Each request passes through history and global/chooser read, local counter
// read through the fetched local history, then evaluate and write back.
// The chain of two dependent RAM reads is why the reads take separate steps.
// After reset a clearing pass steps through 2^max(GHIST_BITS, LHIST_BITS, PC_INDEX_BITS)
// addresses (1024 by default) and loads the tables; no request is taken meanwhile.
// A prediction waits in the evaluate step while the response register is full and not being taken.
`default_nettype none
`include "assert_macros.svh"

module tournament_branch_predictor import tbp_pkg::*; #(
   parameter int GHIST_BITS    = GHIST_BITS_DEF,
   parameter int LHIST_BITS    = LHIST_BITS_DEF,
   parameter int PC_INDEX_BITS = PC_INDEX_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tbp_req_if.sink    req_ch,
   tbp_rsp_if.source  rsp_ch,
   input  wire logic  csr_we,
   input  wire logic  csr_wdata
);

   localparam int GDEPTH = 1 << GHIST_BITS;
   localparam int LDEPTH = 1 << LHIST_BITS;
   localparam int PDEPTH = 1 << PC_INDEX_BITS;
   localparam int GL_BITS  = (GHIST_BITS > LHIST_BITS) ? GHIST_BITS : LHIST_BITS;
   localparam int CLR_BITS = (GL_BITS > PC_INDEX_BITS) ? GL_BITS : PC_INDEX_BITS;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_LREAD = 4'b0100,
      S_EVAL  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CLR_BITS-1:0]    clr_ff, clr_in;
   opcode_type             op_ff;
   logic [PC_INDEX_BITS-1:0] pidx_ff;
   logic                   taken_ff;
   logic [GHIST_BITS-1:0]  ghist_ff, ghist_in;
   logic [LHIST_BITS-1:0]  lhist_ff;
   logic                   mode_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_taken_ff;

   logic [3:0]             gc_rdata;
   logic [LHIST_BITS-1:0]  lh_rdata;
   ctr_type                lc_rdata;

   logic       accept, clearing, train_wr, out_free, load_rsp;
   ctr_type    gctr, cctr, gctr_new, cctr_new, lctr_new;
   logic       gpred, lpred, pred;
   logic [GHIST_BITS-1:0] ghist_next;
   logic [LHIST_BITS-1:0] lhist_next;

   assign clearing = (state_ff == S_CLEAR);
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign train_wr = (state_ff == S_EVAL) && (op_ff == OP_TRAIN);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_rsp = (state_ff == S_EVAL) && (op_ff == OP_PREDICT) && out_free;

   assign gctr  = gc_rdata[1:0];
   assign cctr  = gc_rdata[3:2];
   assign gpred = gctr[1];
   assign lpred = lc_rdata[1];
   assign pred  = (mode_ff == MODE_STATIC) ? 1'b1 : (cctr[1] ? gpred : lpred);

   assign gctr_new = bump(gctr, taken_ff);
   assign lctr_new = bump(lc_rdata, taken_ff);
   assign cctr_new = (gpred != lpred) ? bump(cctr, gpred == taken_ff) : cctr;
   assign ghist_next = GHIST_BITS'({ghist_ff, taken_ff});
   assign lhist_next = LHIST_BITS'({lhist_ff, taken_ff});

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = CLR_BITS'(clr_ff + 1'b1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_LREAD;
         end
         S_LREAD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // hold a prediction until the response register frees up
            if (op_ff == OP_TRAIN || out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      ghist_in = train_wr ? ghist_next : ghist_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ghist_ff     <= '0;
         mode_ff      <= MODE_TOURNAMENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ghist_ff     <= ghist_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_ch.opcode;
         pidx_ff  <= req_ch.branch_pc[PC_INDEX_BITS-1:0];
         taken_ff <= req_ch.actual_taken;
      end
      if (state_ff == S_LREAD) lhist_ff <= lh_rdata;
      if (load_rsp) rsp_taken_ff <= pred;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.predict_taken = rsp_taken_ff;

   // chooser in the upper two bits, global counter in the lower two
   tbp_ram #(.WIDTH(4), .DEPTH(GDEPTH)) u_gc_ram (
      .clock (clock),
      .we    (clearing || train_wr),
      .waddr (clearing ? clr_ff[GHIST_BITS-1:0] : ghist_ff),
      .wdata (clearing ? {CTR_WEAK_GLOBAL, CTR_WEAK_NT} : {cctr_new, gctr_new}),
      .re    (accept),
      .raddr (ghist_ff),
      .rdata (gc_rdata)
   );

   tbp_ram #(.WIDTH(LHIST_BITS), .DEPTH(PDEPTH)) u_lh_ram (
      .clock (clock),
      .we    (clearing || train_wr),
      .waddr (clearing ? clr_ff[PC_INDEX_BITS-1:0] : pidx_ff),
      .wdata (clearing ? {LHIST_BITS{1'b0}} : lhist_next),
      .re    (accept),
      .raddr (req_ch.branch_pc[PC_INDEX_BITS-1:0]),
      .rdata (lh_rdata)
   );

   tbp_ram #(.WIDTH(2), .DEPTH(LDEPTH)) u_lc_ram (
      .clock (clock),
      .we    (clearing || train_wr),
      .waddr (clearing ? clr_ff[LHIST_BITS-1:0] : lhist_ff),
      .wdata (clearing ? CTR_WEAK_NT : lctr_new),
      .re    (state_ff == S_LREAD),
      .raddr (lh_rdata),
      .rdata (lc_rdata)
   );

   `TBP_ASSERT_NEXT(a_accept_to_lread, clock, reset, accept, state_ff == S_LREAD)
   `TBP_ASSERT_NEXT(a_ghist_shift, clock, reset, train_wr, ghist_ff == $past(ghist_next))
   `TBP_ASSERT_NEXT(a_pred_waits, clock, reset,
      (state_ff == S_EVAL) && (op_ff == OP_PREDICT) && !out_free,
      (state_ff == S_EVAL) && rsp_valid_ff)
   `TBP_ASSERT_NEXT(a_static_taken, clock, reset,
      load_rsp && (mode_ff == MODE_STATIC), rsp_valid_ff && rsp_taken_ff)
   `TBP_ASSERT_SAME(a_no_accept_clear, clock, reset, clearing, !accept && !rsp_valid_ff)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import tbp_pkg::*;

   localparam int GHB         = GHIST_BITS_DEF;
   localparam int LHB         = LHIST_BITS_DEF;
   localparam int PCB         = PC_INDEX_BITS_DEF;
   localparam int SITES       = 8;
   localparam int LONG_HOLD   = 400;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      opcode_type         opcode;
      logic [PC_BITS-1:0] pc;
      logic               taken;
   } branch_item_type;

   typedef enum int {
      PAT_TAKEN,
      PAT_NOT_TAKEN,
      PAT_ALTERNATE,
      PAT_LOOP,
      PAT_RANDOM
   } pattern_kind_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   tbp_req_if req_ch ();
   tbp_rsp_if rsp_ch ();

   tournament_branch_predictor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the predictor tables
   ctr_type        gbl_ctr   [0:(1<<GHB)-1];
   ctr_type        chooser   [0:(1<<GHB)-1];
   ctr_type        loc_ctr   [0:(1<<LHB)-1];
   logic [LHB-1:0] loc_hist  [0:(1<<PCB)-1];
   logic [GHB-1:0] ghist;
   logic           mode_shadow;

   branch_item_type branch_items_q [$];
   logic            predicted_q    [$];

   logic [PC_BITS-1:0] site_pc     [SITES];
   pattern_kind_type   site_kind   [SITES];
   int                 site_period [SITES];
   int                 site_count  [SITES];

   int          err_count;
   int          cycle_count;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          req_gap_left;
   int          rsp_stall_left;
   int          hold_asked;
   int          hold_seen;
   branch_item_type nxt_item;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= 20)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic ctr_type counter_step(input ctr_type c, input logic up);
      if (up)
         return (c == CTR_MAX) ? c : ctr_type'(c + 2'd1);
      return (c == CTR_MIN) ? c : ctr_type'(c - 2'd1);
   endfunction

   task automatic clear_tables();
      for (int i = 0; i < (1 << GHB); i++) begin
         gbl_ctr[i] = CTR_WEAK_NT;
         chooser[i] = CTR_WEAK_GLOBAL;
      end
      for (int i = 0; i < (1 << LHB); i++)
         loc_ctr[i] = CTR_WEAK_NT;
      for (int i = 0; i < (1 << PCB); i++)
         loc_hist[i] = '0;
      ghist       = '0;
      mode_shadow = MODE_TOURNAMENT;
   endtask

   // Predict pushes the expected direction; train updates counters and histories.
   task automatic predict_or_train(input branch_item_type it);
      logic [PCB-1:0] pidx;
      logic [GHB-1:0] gidx;
      logic [LHB-1:0] lidx;
      logic           gp;
      logic           lp;
      pidx = it.pc[PCB-1:0];
      gidx = ghist;
      lidx = loc_hist[pidx];
      gp   = gbl_ctr[gidx] >= CTR_WEAK_GLOBAL;
      lp   = loc_ctr[lidx] >= CTR_WEAK_GLOBAL;
      if (it.opcode == OP_PREDICT) begin
         if (mode_shadow == MODE_STATIC)
            predicted_q.push_back(1'b1);
         else
            predicted_q.push_back((chooser[gidx] > CTR_WEAK_NT) ? gp : lp);
      end else begin
         loc_ctr[lidx]  = counter_step(loc_ctr[lidx], it.taken);
         gbl_ctr[gidx]  = counter_step(gbl_ctr[gidx], it.taken);
         loc_hist[pidx] = {loc_hist[pidx][LHB-2:0], it.taken};
         // chooser learns only from disagreements
         if (gp != lp)
            chooser[gidx] = counter_step(chooser[gidx], gp == it.taken);
         ghist = {ghist[GHB-2:0], it.taken};
      end
   endtask

   function automatic int pick_gap(input int idle_pct);
      int r;
      if (idle_pct == 0 || $urandom_range(99) >= idle_pct)
         return 0;
      r = $urandom_range(99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap_left <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_gap_left > 0) begin
            req_ch.valid <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (branch_items_q.size() > 0) begin
            nxt_item = branch_items_q.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.opcode       <= nxt_item.opcode;
            req_ch.branch_pc    <= nxt_item.pc;
            req_ch.actual_taken <= nxt_item.taken;
            req_gap_left        <= pick_gap(req_idle_pct);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response sink with random stalls and a long hold when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         rsp_stall_left <= 0;
      end else if (hold_seen != hold_asked) begin
         hold_seen      <= hold_asked;
         rsp_ch.ready   <= 1'b0;
         rsp_stall_left <= LONG_HOLD;
      end else if (rsp_stall_left > 0) begin
         rsp_ch.ready   <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_ch.ready   <= 1'b1;
         rsp_stall_left <= pick_gap(rsp_idle_pct);
      end
   end

   // Monitor: check responses, then advance the shadow tables
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_q.size() == 0)
               report_mismatch("response transaction with no prediction pending");
            else if (rsp_ch.predict_taken !== predicted_q[0])
               report_mismatch($sformatf("predict_taken got %b expected %b",
                                         rsp_ch.predict_taken, predicted_q[0]));
            if (predicted_q.size() > 0)
               void'(predicted_q.pop_front());
         end
         if (req_ch.valid && req_ch.ready)
            predict_or_train('{req_ch.opcode, req_ch.branch_pc, req_ch.actual_taken});
      end
   end

   task automatic add_item(input opcode_type op, input logic [PC_BITS-1:0] pc,
                           input logic taken);
      branch_items_q.push_back('{op, pc, taken});
   endtask

   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
      mode_shadow = m;
   endtask

   // Hold until every item is accepted and every prediction returned
   task automatic wait_drained(input int settle);
      do
         @(posedge clock);
      while (branch_items_q.size() != 0 || req_ch.valid || predicted_q.size() != 0);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic new_sites();
      for (int s = 0; s < SITES; s++) begin
         site_pc[s]     = $urandom;
         site_kind[s]   = pattern_kind_type'($urandom_range(PAT_RANDOM));
         site_period[s] = $urandom_range(2, 7);
         site_count[s]  = 0;
      end
      // last site aliases the first in the local history table
      site_pc[SITES-1] = {~site_pc[0][PC_BITS-1:PCB], site_pc[0][PCB-1:0]};
   endtask

   function automatic logic site_outcome(input int s);
      logic o;
      case (site_kind[s])
         PAT_TAKEN:     o = 1'b1;
         PAT_NOT_TAKEN: o = 1'b0;
         PAT_ALTERNATE: o = (site_count[s] % 2) == 0;
         PAT_LOOP:      o = (site_count[s] % site_period[s]) != site_period[s] - 1;
         default:       o = 1'($urandom_range(1));
      endcase
      site_count[s]++;
      return o;
   endfunction

   // Mostly predict-then-train pairs on a few branch sites, some noise
   task automatic add_random(input int n);
      int   count;
      int   r;
      int   s;
      logic o;
      count = 0;
      while (count < n) begin
         r = $urandom_range(99);
         if (r < 70) begin
            s = $urandom_range(SITES - 1);
            o = site_outcome(s);
            add_item(OP_PREDICT, site_pc[s], 1'($urandom_range(1)));
            add_item(OP_TRAIN, site_pc[s], o);
            count += 2;
         end else begin
            add_item((r < 85) ? OP_PREDICT : OP_TRAIN, $urandom, 1'($urandom_range(1)));
            count++;
         end
      end
   endtask

   task automatic add_predict_heavy(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            add_item(OP_TRAIN, site_pc[$urandom_range(SITES - 1)],
                     1'($urandom_range(1)));
         else
            add_item(OP_PREDICT, $urandom, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = MODE_TOURNAMENT;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = OP_PREDICT;
      req_ch.branch_pc    = '0;
      req_ch.actual_taken = 1'b0;
      rsp_ch.ready        = 1'b0;
      err_count           = 0;
      cycle_count         = 0;
      req_idle_pct        = 30;
      rsp_idle_pct        = 30;
      req_gap_left        = 0;
      rsp_stall_left      = 0;
      hold_asked          = 0;
      hold_seen           = 0;
      clear_tables();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_TOURNAMENT);
      @(negedge clock);
      add_item(OP_PREDICT, 32'h0000_0000, 1'b1);
      add_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b0);
      repeat (4) add_item(OP_TRAIN, 32'h0000_0000, 1'b1);  // shift taken outcomes into the histories
      add_item(OP_PREDICT, 32'h0000_0000, 1'b0);
      add_item(OP_TRAIN, 32'hFFFF_FC00, 1'b0);              // aliases PC 0
      repeat (5) add_item(OP_TRAIN, 32'hFFFF_FFFF, 1'b0);  // saturate downward
      add_item(OP_PREDICT, 32'h8000_03FF, 1'b1);
      add_item(OP_TRAIN, 32'h5555_5555, 1'b1);
      add_item(OP_TRAIN, 32'hAAAA_AAAA, 1'b0);
      add_item(OP_PREDICT, 32'hAAAA_AAAA, 1'b1);
      wait_drained(SETTLE);

      // static mode: predictions always taken, training still updates
      write_mode(MODE_STATIC);
      @(negedge clock);
      add_item(OP_PREDICT, 32'h0000_0000, 1'b0);
      add_item(OP_TRAIN, 32'h0000_0000, 1'b0);
      add_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
      add_item(OP_TRAIN, 32'hFFFF_FFFF, 1'b1);
      add_item(OP_PREDICT, 32'h1234_5678, 1'b0);
      wait_drained(SETTLE);

      write_mode(MODE_TOURNAMENT);
      @(negedge clock);
      new_sites();
      add_random(300);
      wait_drained(SETTLE);

      // back-pressure: sink holds off while the source keeps offering
      req_idle_pct = 0;
      hold_asked   = hold_asked + 1;
      add_predict_heavy(120);
      wait_drained(SETTLE);

      write_mode(MODE_STATIC);
      @(negedge clock);
      req_idle_pct = 30;
      rsp_idle_pct = 40;
      new_sites();
      add_random(150);
      wait_drained(SETTLE);

      // full-rate stretch, no idling on either side
      write_mode(MODE_TOURNAMENT);
      @(negedge clock);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      new_sites();
      add_random(180);
      wait_drained(SETTLE + 12);

      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tbp_pkg.sv
rtl/tbp_channels.sv
rtl/tbp_ram.sv
rtl/tournament_branch_predictor.sv
tb/tb_top.sv
